>>> rtl/core/qr_module_pattern_generator_unit_macros.svh
// Assertion macros shared by the QR module pattern generator RTL.
`ifndef QR_MODULE_PATTERN_GENERATOR_UNIT_MACROS_SVH
`define QR_MODULE_PATTERN_GENERATOR_UNIT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold from the same clock edge.
`define QRMPG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The expression must hold at every clock edge outside reset.
`define QRMPG_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

>>> rtl/core/qrmpg_pkg.sv
// Types, constants and tables shared by the QR module pattern generator.
`default_nettype none

package qrmpg_pkg;

  // Width of an alignment position index (at most seven positions per axis).
  localparam int IDX_W = 3;

  typedef logic [3:0] cfg_idx_t;
  localparam cfg_idx_t CFG_VERSION = 4'd0;
  localparam cfg_idx_t CFG_MASK    = 4'd1;
  localparam cfg_idx_t CFG_FORMAT  = 4'd2;
  localparam cfg_idx_t CFG_VWORD   = 4'd3;

  typedef logic [2:0] mask_t;
  localparam mask_t MASK_CHECKER  = 3'd0;
  localparam mask_t MASK_ROWS     = 3'd1;
  localparam mask_t MASK_COLS3    = 3'd2;
  localparam mask_t MASK_DIAG3    = 3'd3;
  localparam mask_t MASK_BLOCKS   = 3'd4;
  localparam mask_t MASK_PROD     = 3'd5;
  localparam mask_t MASK_PROD_ALT = 3'd6;
  localparam mask_t MASK_MIXED    = 3'd7;

  localparam logic [5:0]  VER_MIN       = 6'd1;
  localparam logic [5:0]  VER_MAX       = 6'd40;
  localparam logic [5:0]  VER_RESET     = 6'd1;
  localparam mask_t       MASK_RESET    = MASK_CHECKER;
  localparam logic [14:0] FORMAT_RESET  = 15'b101010000010010;
  localparam logic [17:0] VWORD_RESET   = 18'b000111110010010100;

  // Version update towards the alignment unit.
  typedef struct packed {
    logic       wr;
    logic [5:0] ver;
  } ver_upd_t;

  // Alignment lookup result for the current module.
  typedef struct packed {
    logic hit;
    logic dark;
  } align_res_t;

  function automatic logic [5:0] clamp_version(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (v < VER_MIN) r = VER_MIN;
    if (v > VER_MAX) r = VER_MAX;
    return r;
  endfunction

  // Finder pattern colour at offset (dx, dy) within the 7 by 7 pattern.
  function automatic logic finder_dark(input logic [2:0] dx, input logic [2:0] dy);
    logic ring;
    logic core;
    ring = (dx == 3'd0) || (dx == 3'd6) || (dy == 3'd0) || (dy == 3'd6);
    core = (dx >= 3'd2) && (dx <= 3'd4) && (dy >= 3'd2) && (dy <= 3'd4);
    return ring || core;
  endfunction

  // Number of alignment positions per axis for a version.
  function automatic logic [IDX_W-1:0] align_num(input logic [5:0] v);
    logic [IDX_W-1:0] r;
    if (v < 6'd7)       r = 3'd2;
    else if (v < 6'd14) r = 3'd3;
    else if (v < 6'd21) r = 3'd4;
    else if (v < 6'd28) r = 3'd5;
    else if (v < 6'd35) r = 3'd6;
    else                r = 3'd7;
    return r;
  endfunction

  // Spacing between the inner alignment positions for a version.
  function automatic logic [4:0] align_step(input logic [5:0] v);
    logic [4:0] r;
    case (v)
      6'd2:                r = 5'd12;
      6'd3:                r = 5'd16;
      6'd4:                r = 5'd20;
      6'd5:                r = 5'd24;
      6'd6:                r = 5'd28;
      6'd7:                r = 5'd16;
      6'd8:                r = 5'd18;
      6'd9:                r = 5'd20;
      6'd10:               r = 5'd22;
      6'd11:               r = 5'd24;
      6'd12:               r = 5'd26;
      6'd13:               r = 5'd28;
      6'd14:               r = 5'd20;
      6'd15:               r = 5'd22;
      6'd16, 6'd17:        r = 5'd24;
      6'd18:               r = 5'd26;
      6'd19, 6'd20:        r = 5'd28;
      6'd21:               r = 5'd22;
      6'd22, 6'd23:        r = 5'd24;
      6'd24, 6'd25:        r = 5'd26;
      6'd26, 6'd27:        r = 5'd28;
      6'd28, 6'd29:        r = 5'd24;
      6'd30, 6'd31, 6'd32: r = 5'd26;
      6'd33, 6'd34:        r = 5'd28;
      6'd35:               r = 5'd24;
      6'd36, 6'd37, 6'd38: r = 5'd26;
      6'd39, 6'd40:        r = 5'd28;
      default:             r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/qrmpg_align.sv
// Alignment pattern position registers and the per-module alignment lookup.
`default_nettype none

`include "qr_module_pattern_generator_unit_macros.svh"

module qrmpg_align import qrmpg_pkg::*; #(
  parameter int LANES = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  ver_upd_t   upd,
  input  logic [7:0] x,
  input  logic [7:0] y,
  output align_res_t res
);

  logic [7:0]       pos [LANES];
  logic [7:0]       pos_next [LANES];
  logic [LANES-1:0] lane_on;
  logic [LANES-1:0] lane_on_next;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] last_idx_next;
  logic             align_en;

  logic [7:0]       side;
  logic [7:0]       base;
  logic [IDX_W-1:0] num;
  logic [4:0]       step;
  logic [IDX_W-1:0] k;

  logic [LANES-1:0] near_x;
  logic [LANES-1:0] near_y;
  logic [1:0]       dist_x [LANES];
  logic [1:0]       dist_y [LANES];
  logic [IDX_W-1:0] ix;
  logic [IDX_W-1:0] iy;
  logic [1:0]       dx;
  logic [1:0]       dy;
  logic [1:0]       dmax;
  logic             excl;

  // Positions are worked out once, when the version register is written.
  always_comb begin
    num           = align_num(upd.ver);
    step          = align_step(upd.ver);
    side          = 8'd17 + {upd.ver, 2'b00};
    base          = side - 8'd7;
    last_idx_next = num - 3'd1;
    k             = '0;
    for (int i = 0; i < LANES; i++) begin
      k               = num - 3'd1 - IDX_W'(i);
      lane_on_next[i] = IDX_W'(i) < num;
      if (i == 0) begin
        pos_next[i] = 8'd6;
      end else begin
        pos_next[i] = base - ({5'd0, k} * {3'd0, step});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_on  <= '0;
      last_idx <= '0;
      align_en <= 1'b0;
    end else if (upd.wr) begin
      lane_on  <= lane_on_next;
      last_idx <= last_idx_next;
      align_en <= upd.ver >= 6'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.wr) begin
      pos <= pos_next;
    end
  end

  // Each lane checks whether the module lies within two of its centre.
  always_comb begin
    logic [8:0] diff;
    logic [8:0] mag;
    diff = '0;
    mag  = '0;
    for (int i = 0; i < LANES; i++) begin
      diff      = {1'b0, x} - {1'b0, pos[i]};
      mag       = diff[8] ? (9'd0 - diff) : diff;
      near_x[i] = lane_on[i] && (mag <= 9'd2);
      dist_x[i] = mag[1:0];
      diff      = {1'b0, y} - {1'b0, pos[i]};
      mag       = diff[8] ? (9'd0 - diff) : diff;
      near_y[i] = lane_on[i] && (mag <= 9'd2);
      dist_y[i] = mag[1:0];
    end
  end

  // Centres are at least twelve apart, so at most one lane per axis is near.
  always_comb begin
    ix = '0;
    iy = '0;
    dx = '0;
    dy = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (near_x[i]) begin
        ix = IDX_W'(i);
        dx = dist_x[i];
      end
      if (near_y[i]) begin
        iy = IDX_W'(i);
        dy = dist_y[i];
      end
    end
    excl = ((ix == '0) && (iy == '0)) || ((ix == '0) && (iy == last_idx)) ||
           ((ix == last_idx) && (iy == '0));
    dmax     = (dx > dy) ? dx : dy;
    res.hit  = align_en && (|near_x) && (|near_y) && !excl;
    res.dark = (dmax == 2'd2) || (dmax == 2'd0);
  end

  `QRMPG_ASSERT_ALWAYS(a_near_x_single, $onehot0(near_x), "two alignment columns match")
  `QRMPG_ASSERT_ALWAYS(a_near_y_single, $onehot0(near_y), "two alignment rows match")
  `QRMPG_ASSERT_IMPLY(a_hit_needs_lanes, res.hit, (|lane_on) && align_en, "hit without lanes")

endmodule

`default_nettype wire

>>> rtl/core/qr_module_pattern_generator_unit.sv
// Top level of the QR module pattern generator: configuration, pipeline and classification.
`default_nettype none

`include "qr_module_pattern_generator_unit_macros.svh"

// One module coordinate is taken per clock whenever start is high and busy is low; busy is
// high only during reset. Each transfer yields exactly one result, shown with done after the
// input register and then the result register, in order; the receiver cannot stall and
// need not. The classification is a single registered pass, so the rate is one module per
// cycle. Configuration writes are always taken (cfg_ready is high) and must be made while no
// coordinate is in flight. A version write also loads the alignment centre registers in the
// same cycle, so a coordinate may follow straight away.
module qr_module_pattern_generator_unit import qrmpg_pkg::*; #(
  parameter int MAX_ALIGN_POSITIONS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  column,
  input  logic [7:0]  row,
  output logic        done,
  output logic        dark,
  output logic        is_function,
  output logic        inside_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [17:0] cfg_data
);

  logic [5:0]  ver;
  mask_t       mask_sel;
  logic [14:0] fmt_word;
  logic [17:0] vrs_word;

  logic        s1_valid;
  logic [7:0]  s1_col;
  logic [7:0]  s1_row;

  ver_upd_t    upd;
  align_res_t  ares;

  logic [7:0]  side;
  logic [7:0]  n_m1;
  logic [7:0]  n_m7;
  logic [7:0]  n_m8;
  logic [7:0]  n_m9;
  logic [7:0]  n_m11;
  logic [7:0]  tr_dx;
  logic [7:0]  bl_dy;
  logic [7:0]  fr_off;
  logic [7:0]  fb_off;
  logic [7:0]  vb_off;
  logic [7:0]  vr_off;
  logic [3:0]  fidx;
  logic [4:0]  vidx;
  logic        dark_next;
  logic        fn_next;
  logic        ins_next;

  function automatic logic [7:0] div3(input logic [7:0] v);
    logic [16:0] prod;
    prod = {9'd0, v} * 17'd171;
    return prod[16:9];
  endfunction

  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [7:0] q;
    logic [8:0] t;
    logic [7:0] r;
    q = div3(v);
    t = {q, 1'b0} + {1'b0, q};
    r = v - t[7:0];
    return r[1:0];
  endfunction

  function automatic logic mask_bit(input mask_t sel, input logic [7:0] x,
                                    input logic [7:0] y);
    logic [1:0] xm;
    logic [1:0] ym;
    logic [2:0] s;
    logic [1:0] sm;
    logic [1:0] pm;
    logic       p2;
    logic [7:0] xq;
    logic       r;
    xm = mod3(x);
    ym = mod3(y);
    s  = {1'b0, xm} + {1'b0, ym};
    sm = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    // The product modulo three follows from the residues of the factors.
    pm = ((xm == 2'd0) || (ym == 2'd0)) ? 2'd0 : ((xm == ym) ? 2'd1 : 2'd2);
    p2 = x[0] & y[0];
    xq = div3(x);
    case (sel)
      MASK_CHECKER:  r = ~(x[0] ^ y[0]);
      MASK_ROWS:     r = ~y[0];
      MASK_COLS3:    r = (xm == 2'd0);
      MASK_DIAG3:    r = (sm == 2'd0);
      MASK_BLOCKS:   r = ~(y[1] ^ xq[0]);
      MASK_PROD:     r = !p2 && (pm == 2'd0);
      MASK_PROD_ALT: r = ~(p2 ^ pm[0]);
      MASK_MIXED:    r = ~(x[0] ^ y[0] ^ pm[0]);
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ver      <= VER_RESET;
      mask_sel <= MASK_RESET;
      fmt_word <= FORMAT_RESET;
      vrs_word <= VWORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VERSION: ver      <= clamp_version(cfg_data[5:0]);
        CFG_MASK:    mask_sel <= cfg_data[2:0];
        CFG_FORMAT:  fmt_word <= cfg_data[14:0];
        CFG_VWORD:   vrs_word <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign upd.wr  = cfg_valid && cfg_ready && (cfg_index == CFG_VERSION);
  assign upd.ver = clamp_version(cfg_data[5:0]);

  qrmpg_align #(
    .LANES (MAX_ALIGN_POSITIONS)
  ) u_align (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .x   (s1_col),
    .y   (s1_row),
    .res (ares)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_col <= column;
    s1_row <= row;
  end

  assign side   = 8'd17 + {ver, 2'b00};
  assign n_m1   = side - 8'd1;
  assign n_m7   = side - 8'd7;
  assign n_m8   = side - 8'd8;
  assign n_m9   = side - 8'd9;
  assign n_m11  = side - 8'd11;
  assign tr_dx  = s1_col - n_m7;
  assign bl_dy  = s1_row - n_m7;
  assign fr_off = n_m1 - s1_col;
  assign fb_off = s1_row + 8'd15 - side;
  assign vb_off = s1_row - n_m11;
  assign vr_off = s1_col - n_m11;

  // Earlier tests take priority; the order matches the layout rules of the symbol.
  always_comb begin
    dark_next = 1'b0;
    fn_next   = 1'b1;
    ins_next  = 1'b1;
    fidx      = '0;
    vidx      = '0;
    if (s1_col >= side || s1_row >= side) begin
      fn_next  = 1'b0;
      ins_next = 1'b0;
    end else if (s1_col <= 8'd7 && s1_row <= 8'd7) begin
      dark_next = (s1_col <= 8'd6) && (s1_row <= 8'd6) &&
                  finder_dark(s1_col[2:0], s1_row[2:0]);
    end else if (s1_col >= n_m8 && s1_row <= 8'd7) begin
      dark_next = (s1_col >= n_m7) && (s1_row <= 8'd6) &&
                  finder_dark(tr_dx[2:0], s1_row[2:0]);
    end else if (s1_col <= 8'd7 && s1_row >= n_m8) begin
      dark_next = (s1_row >= n_m7) && (s1_col <= 8'd6) &&
                  finder_dark(s1_col[2:0], bl_dy[2:0]);
    end else if (s1_col == 8'd8 && s1_row <= 8'd8 && s1_row != 8'd6) begin
      fidx      = (s1_row < 8'd6) ? s1_row[3:0] : (s1_row[3:0] - 4'd1);
      dark_next = (fidx == 4'd15) ? 1'b0 : fmt_word[fidx];
    end else if (s1_row == 8'd8 && s1_col <= 8'd7 && s1_col != 8'd6) begin
      fidx      = (s1_col == 8'd7) ? 4'd8 : (4'd14 - s1_col[3:0]);
      dark_next = (fidx == 4'd15) ? 1'b0 : fmt_word[fidx];
    end else if (s1_row == 8'd8 && s1_col >= n_m8) begin
      fidx      = fr_off[3:0];
      dark_next = (fidx == 4'd15) ? 1'b0 : fmt_word[fidx];
    end else if (s1_col == 8'd8 && s1_row == n_m8) begin
      // The single dark module beside the lower left finder.
      dark_next = 1'b1;
    end else if (s1_col == 8'd8 && s1_row >= n_m7) begin
      fidx      = fb_off[3:0];
      dark_next = (fidx == 4'd15) ? 1'b0 : fmt_word[fidx];
    end else if (ver >= 6'd7 && s1_col <= 8'd5 && s1_row >= n_m11 && s1_row <= n_m9) begin
      vidx      = ({s1_col[2:0], 1'b0} + {1'b0, s1_col[2:0]}) + {3'd0, vb_off[1:0]};
      dark_next = (vidx > 5'd17) ? 1'b0 : vrs_word[vidx];
    end else if (ver >= 6'd7 && s1_row <= 8'd5 && s1_col >= n_m11 && s1_col <= n_m9) begin
      vidx      = ({s1_row[2:0], 1'b0} + {1'b0, s1_row[2:0]}) + {3'd0, vr_off[1:0]};
      dark_next = (vidx > 5'd17) ? 1'b0 : vrs_word[vidx];
    end else if (ares.hit) begin
      dark_next = ares.dark;
    end else if (s1_row == 8'd6) begin
      dark_next = ~s1_col[0];
    end else if (s1_col == 8'd6) begin
      dark_next = ~s1_row[0];
    end else begin
      fn_next   = 1'b0;
      dark_next = mask_bit(mask_sel, s1_col, s1_row);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    dark        <= dark_next;
    is_function <= fn_next;
    inside_res  <= ins_next;
  end

  `QRMPG_ASSERT_IMPLY(a_result_follows, start && !busy, ##2 done, "transfer without result")
  `QRMPG_ASSERT_IMPLY(a_outside_clear, done && !inside_res, !dark && !is_function,
                      "module outside the symbol is not blank")
  `QRMPG_ASSERT_IMPLY(a_version_clamped, cfg_valid && cfg_ready && cfg_index == CFG_VERSION,
                      ##1 (ver >= VER_MIN && ver <= VER_MAX), "version out of range")

endmodule

`default_nettype wire
